// ===== hdl/brdc_pkg.sv =====
// shared widths and constants for the box resampler with dc blocker
package brdc_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int RATIO_W        = 23;
  localparam int SUM_W          = 40;
  localparam int INTEG_W        = 32;
  localparam int HP_OUT_W       = 17;
  localparam int HP_SHIFT       = 15;
  localparam int HP_COEFF_SHIFT = 6;
  localparam int CNT_W          = $clog2(SUM_W);

  localparam logic [RATIO_W-1:0] RATIO_RESET = 23'd341333;

endpackage

// ===== hdl/box_resampler_dc_blocker_core.sv =====
// fractional box-filter decimator with a leaky dc-blocking high-pass filter
//
// The input channel (in_valid, in_stall, in_sample_in) takes one signed
// high-rate sample per transfer. Each output window covers step_ratio input
// samples, unsigned fixed point with FRACTION_BITS fraction bits, and
// produces one transfer on the output channel (out_valid, out_stall,
// out_sample_out). Samples on a window edge are split by weight.
// The window sum is divided by the ratio in a shared restoring divider that
// resolves one quotient bit per cycle over the 40-bit sum. A window-closing
// item passes the accumulate, sign, divide and filter states; any other item
// returns to idle after accumulating. in_stall is high while one is in work.
// The result sits in an output register; the next sample is taken while it
// waits, but a following result waits until the receiver has taken it,
// holding the input stalled meanwhile.
// cfg_wr_en writes cfg_wr_data into step_ratio; write it only while idle.
// A ratio below one is used as exactly one.
// Synchronous reset clears the window and filter state, sets step_ratio and
// the window length to 341333 and empties the output register.
module box_resampler_dc_blocker_core #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic        [brdc_pkg::RATIO_W-1:0]   cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [brdc_pkg::SAMPLE_W-1:0]  in_sample_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [brdc_pkg::SAMPLE_W-1:0]  out_sample_out
);

  localparam int SW = brdc_pkg::SAMPLE_W;
  localparam int RW = brdc_pkg::RATIO_W;
  localparam int AW = brdc_pkg::SUM_W;
  localparam int IW = brdc_pkg::INTEG_W;
  localparam int PW = brdc_pkg::HP_OUT_W;
  localparam int CW = brdc_pkg::CNT_W;
  localparam logic [RW-1:0] ONE      = RW'(1) << FRACTION_BITS;
  localparam logic [CW-1:0] CNT_LAST = CW'(AW - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_ABS,
    ST_DIV,
    ST_HP_INT,
    ST_HP_OUT
  } state_t;

  state_t                  state_r;
  logic [CW-1:0]           cnt_r;
  logic                    out_valid_r;
  logic signed [SW-1:0]    out_sample_r;
  logic [RW-1:0]           step_ratio_r;
  logic signed [AW-1:0]    window_sum_r;
  logic [RW-1:0]           window_rem_r;
  logic signed [SW-1:0]    hp_prev_in_r;
  logic signed [IW-1:0]    hp_integ_r;
  logic signed [PW-1:0]    hp_prev_out_r;

  logic signed [SW-1:0]    x_r;
  logic [AW-1:0]           dvd_r;
  logic [RW-1:0]           rem_r;
  logic [SW-1:0]           quo_r;
  logic                    neg_r;

  logic [RW-1:0]           ratio_eff;
  logic signed [AW-1:0]    prod;
  logic signed [AW-1:0]    x_one;
  logic                    win_full;
  logic [RW-1:0]           rem_dec;
  logic signed [AW-1:0]    sum_full_nxt;
  logic signed [AW-1:0]    total_edge;
  logic signed [AW-1:0]    sum_edge_nxt;
  logic [RW-1:0]           rem_edge_nxt;
  logic [RW:0]             div_trial;
  logic                    div_ge;
  logic [RW:0]             div_diff;
  logic signed [SW-1:0]    hp_x;
  logic signed [SW:0]      hp_diff;
  logic signed [IW-1:0]    hp_integ_nxt;
  logic                    hp_round;
  logic signed [PW-1:0]    hp_prev_out_nxt;
  logic                    in_xfer;
  logic                    out_free;

  assign in_stall       = (state_r != ST_IDLE);
  assign in_xfer        = in_valid && !in_stall;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_free       = !out_valid_r || !out_stall;

  assign ratio_eff = (step_ratio_r < ONE) ? ONE : step_ratio_r;

  // window weighting
  assign prod         = AW'(x_r * $signed({1'b0, window_rem_r}));
  assign x_one        = AW'(x_r) <<< FRACTION_BITS;
  assign win_full     = (window_rem_r >= ONE);
  assign rem_dec      = window_rem_r - ONE;
  assign sum_full_nxt = window_sum_r + x_one;
  assign total_edge   = window_sum_r + prod;
  assign sum_edge_nxt = x_one - prod;
  assign rem_edge_nxt = ratio_eff - ONE + window_rem_r;

  // one restoring divide step
  assign div_trial = {rem_r, dvd_r[AW-1]};
  assign div_ge    = (div_trial >= {1'b0, ratio_eff});
  assign div_diff  = div_trial - {1'b0, ratio_eff};

  // dc blocker
  assign hp_x         = neg_r ? -$signed(quo_r) : $signed(quo_r);
  assign hp_diff      = (SW+1)'(hp_x) - (SW+1)'(hp_prev_in_r);
  assign hp_integ_nxt = hp_integ_r + (IW'(hp_diff) <<< brdc_pkg::HP_SHIFT)
                        - (IW'(hp_prev_out_r) <<< brdc_pkg::HP_COEFF_SHIFT);
  assign hp_round        = hp_integ_r[IW-1] && (|hp_integ_r[brdc_pkg::HP_SHIFT-1:0]);
  assign hp_prev_out_nxt = hp_integ_r[IW-1:brdc_pkg::HP_SHIFT] + PW'(hp_round);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      out_sample_r  <= '0;
      step_ratio_r  <= brdc_pkg::RATIO_RESET;
      window_sum_r  <= '0;
      window_rem_r  <= brdc_pkg::RATIO_RESET;
      hp_prev_in_r  <= '0;
      hp_integ_r    <= '0;
      hp_prev_out_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        step_ratio_r <= cfg_wr_data;
      end
      if (out_valid_r && !out_stall && (state_r != ST_HP_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            state_r <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          if (win_full) begin
            if (rem_dec != '0) begin
              window_sum_r <= sum_full_nxt;
              window_rem_r <= rem_dec;
              state_r      <= ST_IDLE;
            end else begin
              window_sum_r <= '0;
              window_rem_r <= ratio_eff;
              state_r      <= ST_ABS;
            end
          end else begin
            window_sum_r <= sum_edge_nxt;
            window_rem_r <= rem_edge_nxt;
            state_r      <= ST_ABS;
          end
        end
        ST_ABS: begin
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CNT_LAST) begin
            state_r <= ST_HP_INT;
          end
        end
        ST_HP_INT: begin
          hp_integ_r   <= hp_integ_nxt;
          hp_prev_in_r <= hp_x;
          state_r      <= ST_HP_OUT;
        end
        ST_HP_OUT: begin
          if (out_free) begin
            hp_prev_out_r <= hp_prev_out_nxt;
            out_sample_r  <= hp_prev_out_nxt[SW-1:0];
            out_valid_r   <= 1'b1;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // input capture and datapath of the shared divider
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          x_r <= in_sample_in;
        end
      end
      ST_ACCUM: begin
        dvd_r <= win_full ? sum_full_nxt : total_edge;
      end
      ST_ABS: begin
        neg_r <= dvd_r[AW-1];
        dvd_r <= dvd_r[AW-1] ? (~dvd_r + AW'(1)) : dvd_r;
        rem_r <= '0;
      end
      ST_DIV: begin
        rem_r <= div_ge ? div_diff[RW-1:0] : div_trial[RW-1:0];
        dvd_r <= {dvd_r[AW-2:0], 1'b0};
        quo_r <= {quo_r[SW-2:0], div_ge};
      end
      ST_HP_INT, ST_HP_OUT: begin
      end
      default: begin
      end
    endcase
  end

endmodule
